/* hdl/sha512_pkg.sv */
// Shared types, constants and functions of the SHA-512 hash core.
package sha512_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        end_of_message;
  } sha512_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } sha512_out_t;

  // Work word queued between the front and the back
  typedef struct packed {
    logic [63:0] word;
    logic        start;    // first word of a new message
    logic        compress; // word completes a block
    logic        emit;     // block ends the message, send digest afterwards
  } sha512_job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_PAD,
    FE_LEN_HI,
    FE_LEN_LO
  } sha512_fe_state_e;

  typedef enum logic [1:0] {
    BE_LOAD,
    BE_ROUND,
    BE_ADD,
    BE_EMIT
  } sha512_be_state_e;

  localparam int unsigned NumRounds = 80;
  localparam logic [2:0]  CfgLastIdx = 3'd7;

  function automatic logic [63:0] round_k(input logic [6:0] r);
    logic [63:0] k;
    case (r)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage

/* hdl/sha512_front.sv */
// Front end: takes message words, tracks length and block position, adds padding.
module sha512_front import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sha512_in_t  in_data_i,
  output logic        job_valid_o,
  input  logic        job_stall_i,
  output sha512_job_t job_o
);

  sha512_fe_state_e state_q, state_d;
  logic        in_msg_q, in_msg_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] len_lo_q, len_lo_d;
  logic [63:0] len_hi_q, len_hi_d;
  logic        pad80_q, pad80_d;   // pending word is the lone 0x80 word
  logic [3:0]  k;
  logic [63:0] mask, word_in;
  logic [63:0] len_lo_base, len_hi_base;
  logic [64:0] len_sum;
  logic        take;

  assign take = (state_q == FE_IDLE) && in_valid_i && !job_stall_i;
  assign in_stall_o = (state_q != FE_IDLE) || job_stall_i;

  // Clamp the byte count, mask the unused bytes, add the 0x80 marker and sum the length
  always_comb begin
    k = in_data_i.end_of_message ? ((in_data_i.byte_count > 4'd8) ? 4'd8
                                    : in_data_i.byte_count) : 4'd8;
    mask = (k == 4'd0) ? 64'h0 : ~(64'hffff_ffff_ffff_ffff >> {k[3:0], 3'b000});
    word_in = in_data_i.data_word & mask;
    if (k != 4'd8) begin
      word_in = word_in | (64'h80 << (7'd56 - {k[2:0], 3'b000}));
    end
    len_lo_base = in_msg_q ? len_lo_q : 64'h0;
    len_hi_base = in_msg_q ? len_hi_q : 64'h0;
    len_sum = {1'b0, len_lo_base} + {61'h0, k};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: begin
        if (take && in_data_i.end_of_message) begin
          if (k == 4'd8) state_d = FE_PAD;
          else if (pos_d == 4'd14) state_d = FE_LEN_HI;
          else state_d = FE_PAD;
        end
      end
      FE_PAD: begin
        if (!job_stall_i && pos_d == 4'd14) state_d = FE_LEN_HI;
      end
      FE_LEN_HI: if (!job_stall_i) state_d = FE_LEN_LO;
      FE_LEN_LO: if (!job_stall_i) state_d = FE_IDLE;
      default: state_d = FE_IDLE;
    endcase
  end

  // Outputs and bookkeeping
  always_comb begin
    job_valid_o = 1'b0;
    job_o = '0;
    in_msg_d = in_msg_q;
    pos_d = pos_q;
    len_lo_d = len_lo_q;
    len_hi_d = len_hi_q;
    pad80_d = pad80_q;
    case (state_q)
      FE_IDLE: begin
        job_valid_o = in_valid_i;
        job_o.word = word_in;
        job_o.start = !in_msg_q;
        job_o.compress = ((in_msg_q ? pos_q : 4'd0) == 4'd15);
        if (take) begin
          pos_d = (in_msg_q ? pos_q : 4'd0) + 4'd1;
          len_lo_d = len_sum[63:0];
          len_hi_d = len_hi_base + {63'h0, len_sum[64]};
          in_msg_d = 1'b1;
          pad80_d = in_data_i.end_of_message && (k == 4'd8);
        end
      end
      FE_PAD: begin
        job_valid_o = 1'b1;
        job_o.word = pad80_q ? 64'h8000_0000_0000_0000 : 64'h0;
        job_o.compress = (pos_q == 4'd15);
        if (!job_stall_i) begin
          pos_d = pos_q + 4'd1;
          pad80_d = 1'b0;
        end
      end
      FE_LEN_HI: begin
        job_valid_o = 1'b1;
        job_o.word = {len_hi_q[60:0], len_lo_q[63:61]};
        if (!job_stall_i) pos_d = pos_q + 4'd1;
      end
      FE_LEN_LO: begin
        job_valid_o = 1'b1;
        job_o.word = {len_lo_q[60:0], 3'b000};
        job_o.compress = 1'b1;
        job_o.emit = 1'b1;
        if (!job_stall_i) begin
          pos_d = 4'd0;
          in_msg_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      in_msg_q <= 1'b0;
      pos_q <= '0;
      len_lo_q <= '0;
      len_hi_q <= '0;
      pad80_q <= 1'b0;
    end else begin
      state_q <= state_d;
      in_msg_q <= in_msg_d;
      pos_q <= pos_d;
      len_lo_q <= len_lo_d;
      len_hi_q <= len_hi_d;
      pad80_q <= pad80_d;
    end
  end

endmodule

/* hdl/sha512_fifo.sv */
// Short job queue between the front end and the compression engine.
module sha512_fifo import sha512_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  output logic        wr_stall_o,
  input  sha512_job_t wr_data_i,
  output logic        rd_valid_o,
  input  logic        rd_stall_i,
  output sha512_job_t rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha512_job_t      mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign wr_stall_o = (cnt_q == (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_valid_o && !rd_stall_i;

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      if (pop)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* hdl/sha512_engine.sv */
// Back end: block buffer, 80-round compression and digest output.
module sha512_engine import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] init_hash_i [8],
  input  logic        job_valid_i,
  output logic        job_stall_o,
  input  sha512_job_t job_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sha512_out_t out_data_o
);

  sha512_be_state_e state_q, state_d;
  logic [63:0] h_q [8];
  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [3:0]  wpos_q;
  logic [6:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        emit_q;
  logic        take;
  logic [63:0] wt, s0, s1, sig0, sig1, ch, maj, t1, t2, w15, w2;

  assign take = (state_q == BE_LOAD) && job_valid_i;
  assign job_stall_o = (state_q != BE_LOAD);

  // Round logic; schedule word shifts through w_q[0]
  always_comb begin
    w15 = w_q[1];
    w2  = w_q[14];
    s0 = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
    s1 = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
    wt = w_q[0];
    sig1 = {v_q[4][13:0], v_q[4][63:14]} ^ {v_q[4][17:0], v_q[4][63:18]}
         ^ {v_q[4][40:0], v_q[4][63:41]};
    sig0 = {v_q[0][27:0], v_q[0][63:28]} ^ {v_q[0][33:0], v_q[0][63:34]}
         ^ {v_q[0][38:0], v_q[0][63:39]};
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + sig1 + ch + round_k(rnd_q) + wt;
    t2 = sig0 + maj;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_LOAD:  if (take && job_i.compress) state_d = BE_ROUND;
      BE_ROUND: if (rnd_q == 7'(NumRounds - 1)) state_d = BE_ADD;
      BE_ADD:   state_d = emit_q ? BE_EMIT : BE_LOAD;
      BE_EMIT:  if (!out_stall_i && oidx_q == 3'd7) state_d = BE_LOAD;
      default:  state_d = BE_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    out_valid_o = (state_q == BE_EMIT);
    out_data_o.digest_word = h_q[oidx_q];
    out_data_o.word_number = oidx_q;
    out_data_o.last_word = (oidx_q == 3'd7);
  end

  // Hash state and working variables
  always_ff @(posedge clk_i) begin
    case (state_q)
      BE_LOAD: begin
        if (take) begin
          w_q[wpos_q] <= job_i.word;
          if (job_i.start) h_q <= init_hash_i;
          if (job_i.compress) begin
            if (job_i.start) v_q <= init_hash_i;
            else v_q <= h_q;
          end
        end
      end
      BE_ROUND: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
      BE_ADD: begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      default: ;
    endcase
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_LOAD;
      wpos_q <= '0;
      rnd_q <= '0;
      oidx_q <= '0;
      emit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        wpos_q <= job_i.start ? 4'd1 : wpos_q + 4'd1;
        emit_q <= job_i.emit;
      end
      if (state_q == BE_ROUND) rnd_q <= (state_d == BE_ADD) ? 7'd0 : rnd_q + 7'd1;
      if (state_q == BE_EMIT && !out_stall_i) oidx_q <= oidx_q + 3'd1;
    end
  end

endmodule

/* hdl/sha512_hash_core.sv */
// Top level of the SHA-512 hash core.
//
//  port group   direction  contents
//  in_*         into core  one message word per transfer (sha512_in_t)
//  out_*        out        one digest word per transfer (sha512_out_t)
//  cfg_*        into core  write of an initial hash word
//
// A full block takes 16 word transfers and then a pass through the round engine
// (80 rounds at one per cycle, then the state add), during which no job is taken.
// The final word adds the padding words (up to one more block) and
// eight digest transfers. Reset is asynchronous and active low.
// Either side may stall at any time; the job queue decouples the word
// front end from the round engine.
module sha512_hash_core import sha512_pkg::*; #(
  parameter int unsigned JobDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sha512_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sha512_out_t out_data_o
);

  logic [63:0] init_q [8];
  logic        fj_valid, fj_stall, bj_valid, bj_stall;
  sha512_job_t fj, bj;

  // Hold initial hash registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) init_q[i] <= '0;
    end else if (cfg_we_i && cfg_idx_i <= CfgLastIdx) begin
      init_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  sha512_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(fj_valid), .job_stall_i(fj_stall), .job_o(fj)
  );

  sha512_fifo #(.Depth(JobDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_stall_o(fj_stall), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_stall_i(bj_stall), .rd_data_o(bj)
  );

  sha512_engine u_engine (
    .clk_i, .rst_ni, .init_hash_i(init_q),
    .job_valid_i(bj_valid), .job_stall_o(bj_stall), .job_i(bj),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // Digest index advances only on a transfer
  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_data_o.word_number ==
      $past(out_data_o.word_number)) else $error("digest index moved while stalled");

  // Last flag marks word seven only
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_number == 3'd7)))
    else $error("last flag mismatch");

  // An accepted input word is also pushed into the job queue
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> fj_valid && !fj_stall)
    else $error("input accepted without queue space");

endmodule

/* tb/sha512_checker.sv */
// Checker: predicts SHA-512 digests from observed transfers and compares them.
module sha512_checker import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  sha512_in_t  in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  sha512_out_t out_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [63:0] iv_regs [8];
  logic [63:0] chain [8];
  logic [63:0] block_words [16];
  logic [127:0] byte_len;
  int unsigned slot;
  logic busy;
  sha512_out_t digest_q [$];

  assign pending_o = digest_q.size();

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Full 80-round compression over the current block into the chain value
  task automatic compress_block();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int i = 16; i < 80; i++) begin
      s0 = rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7);
      s1 = rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 80; r++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(7'(r)) + w[r];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic append_word(input logic [63:0] wd);
    block_words[slot] = wd;
    slot = (slot + 1) % 16;
    if (slot == 0) compress_block();
  endtask

  // Absorb one accepted message word; finish and queue digest on the end mark
  task automatic absorb(input sha512_in_t it);
    int unsigned k;
    logic [63:0] wd;
    logic [127:0] bit_len;
    sha512_out_t d;
    if (!busy) begin
      for (int i = 0; i < 8; i++) chain[i] = iv_regs[i];
      byte_len = '0;
      slot = 0;
      busy = 1'b1;
    end
    if (!it.end_of_message) begin
      append_word(it.data_word);
      byte_len += 128'd8;
      return;
    end
    k = (it.byte_count > 4'd8) ? 8 : it.byte_count;
    wd = (k == 0) ? 64'd0 : (it.data_word & ({64{1'b1}} << (64 - 8 * k)));
    byte_len += 128'(k);
    if (k < 8) append_word(wd | (64'h80 << (56 - 8 * k)));
    else begin
      append_word(wd);
      append_word(64'h80 << 56);
    end
    while (slot != 14) append_word(64'd0);
    bit_len = byte_len << 3;
    append_word(bit_len[127:64]);
    append_word(bit_len[63:0]);
    for (int i = 0; i < 8; i++) begin
      d.digest_word = chain[i];
      d.word_number = 3'(i);
      d.last_word = (i == 7);
      digest_q.push_back(d);
    end
    busy = 1'b0;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    sha512_out_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) iv_regs[i] <= '0;
      busy = 1'b0;
      fail_count_o = 0;
      digest_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) report("unexpected digest transfer", out_data_i.digest_word, 0);
        else begin
          e = digest_q.pop_front();
          if (out_data_i.digest_word !== e.digest_word)
            report("digest_word", out_data_i.digest_word, e.digest_word);
          if (out_data_i.word_number !== e.word_number)
            report("word_number", 64'(out_data_i.word_number), 64'(e.word_number));
          if (out_data_i.last_word !== e.last_word)
            report("last_word", 64'(out_data_i.last_word), 64'(e.last_word));
        end
      end
      if (in_valid_i && !in_stall_i) absorb(in_data_i);
      if (cfg_we_i) iv_regs[cfg_idx_i] <= cfg_wdata_i;
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top: drives messages and register writes into the SHA-512 core.
module tb;
  import sha512_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [63:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  sha512_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sha512_out_t out_data;
  int fail_count, pending;
  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0;
  int sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sha512_hash_core u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  sha512_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_data_i(out_data), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Randomly stall the digest side
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL sha512_hash_core");
      $finish;
    end
  end

  // Present one word and hold it until the transfer; valid stays up for the next word
  task automatic send_word(input logic [63:0] d, input logic [3:0] n, input logic eom);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_word: d, byte_count: n, end_of_message: eom};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_message(input int words, input logic [3:0] tail);
    for (int i = 0; i < words; i++) send_word({$urandom, $urandom}, 4'($urandom), 1'b0);
    send_word({$urandom, $urandom}, tail, 1'b1);
  endtask

  // Drop valid and wait until every expected digest has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic load_iv(input logic [63:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 3'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [63:0] iv [8];
    logic [63:0] sha512_iv [8];
    sha512_iv = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                  64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                  64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_iv(sha512_iv);

    // Directed: empty message, every tail length, oversize count, field extremes
    send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
    for (int k = 1; k <= 8; k++) send_word(64'hffff_ffff_ffff_ffff, 4'(k), 1'b1);
    send_word(64'h0, 4'd15, 1'b1);
    send_word(64'h0123_4567_89ab_cdef, 4'd15, 1'b0);
    send_word(64'hfedc_ba98_7654_3210, 4'd9, 1'b1);
    send_message(14, 4'd7);
    send_message(15, 4'd0);
    wait_drained();

    // All-zero and all-one initial values
    for (int i = 0; i < 8; i++) iv[i] = '0;
    load_iv(iv);
    send_message(1, 4'd8);
    wait_drained();
    for (int i = 0; i < 8; i++) iv[i] = '1;
    load_iv(iv);
    send_message(2, 4'd3);
    wait_drained();

    // Random messages over the idle and stall phases, fresh initial values each phase but the last (standard IV)
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        3: begin idle_pct = 17; stall_pct = 17; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int i = 0; i < 8; i++) iv[i] = {$urandom, $urandom};
      if (ph == 4) load_iv(sha512_iv);
      else load_iv(iv);
      repeat (9) begin
        send_message(($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(5),
                     4'($urandom_range(15)));
        // Rewrite one initial word between messages once the core is idle
        if ($urandom_range(3) == 0) begin
          wait_drained();
          cfg_we <= 1'b1;
          cfg_idx <= 3'($urandom);
          cfg_wdata <= {$urandom, $urandom};
          @(posedge clk);
          cfg_we <= 1'b0;
        end
      end
      wait_drained();
    end

    wait_drained();
    if (fail_count == 0) $display("PASS sha512_hash_core");
    else $display("FAIL sha512_hash_core");
    $finish;
  end

endmodule

/* sim.f */
hdl/sha512_pkg.sv
hdl/sha512_front.sv
hdl/sha512_fifo.sv
hdl/sha512_engine.sv
hdl/sha512_hash_core.sv
tb/sha512_checker.sv
tb/tb.sv
